@@ rtl/wpip_pkg.sv @@
// wpip_pkg: sizes and types for the winding-number point-in-polygon block
// no dependencies; used by winding_point_in_polygon
`default_nettype none

package wpip_pkg;

  localparam int MaxVertices = 16;
  localparam int CoordBits   = 16;
  localparam int AddrBits    = $clog2(MaxVertices);
  localparam int CountBits   = $clog2(MaxVertices + 1);
  localparam int WindBits    = 6;
  localparam int DiffBits    = CoordBits + 1;
  localparam int ProdBits    = 2 * DiffBits;

  localparam logic OpLoad  = 1'b0;
  localparam logic OpQuery = 1'b1;

  typedef struct packed {
    logic signed [CoordBits-1:0] x;
    logic signed [CoordBits-1:0] y;
  } vertex_t;

endpackage

`default_nettype wire

@@ rtl/winding_point_in_polygon.sv @@
// winding_point_in_polygon: vertex store in a synchronous ram, edge walk and winding count
// depends on wpip_pkg
//
//   channel  | ports                                          | handshake
//   ---------+------------------------------------------------+----------------------------
//   input    | in_op, in_vertex_index, in_x_coord, in_y_coord | start & !busy
//   result   | out_inside_res, out_winding                    | out_valid, one-cycle strobe
//   config   | cfg_vertex_count                               | cfg_valid & cfg_ready
//
// a load writes the vertex ram and gives no result; busy stays low
// a query over n vertices reads one vertex a cycle from the ram, so the result strobe
// follows the ram read, difference and product stages; n = 0 gives it on the next cycle
// busy is high from the accept of a query with n > 0 until its result strobe; the ram
// read port and the three-stage determinant pipeline lie between the two
// rst_n clears control and vertex_count; the vertex ram is not cleared
// results are never held off: out_valid lasts exactly one cycle
`default_nettype none

module winding_point_in_polygon (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 start,
  output logic                                busy,
  input  wire                                 in_op,
  input  wire  [wpip_pkg::AddrBits-1:0]       in_vertex_index,
  input  wire  signed [wpip_pkg::CoordBits-1:0] in_x_coord,
  input  wire  signed [wpip_pkg::CoordBits-1:0] in_y_coord,
  output logic                                out_valid,
  output logic                                out_inside_res,
  output logic signed [wpip_pkg::WindBits-1:0] out_winding,
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire  [wpip_pkg::CountBits-1:0]      cfg_vertex_count
);

  localparam int AW = wpip_pkg::AddrBits;
  localparam int CW = wpip_pkg::CountBits;
  localparam int DW = wpip_pkg::DiffBits;
  localparam int PW = wpip_pkg::ProdBits;
  localparam int WW = wpip_pkg::WindBits;

  localparam logic signed [WW-1:0] WindMax = {1'b0, {(WW-1){1'b1}}};
  localparam logic signed [WW-1:0] WindMin = {1'b1, {(WW-1){1'b0}}};

  // vertex ram
  wpip_pkg::vertex_t mem [wpip_pkg::MaxVertices];
  wpip_pkg::vertex_t mem_q_r;
  wpip_pkg::vertex_t wr_data;
  logic              wr_en;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;

  // control
  logic [CW-1:0]     vertex_count_r;
  logic              busy_r;
  logic              issuing_r;
  logic [AW-1:0]     rd_idx_r;
  logic [AW-1:0]     last_idx_r;
  logic              q_vld_r, q_first_r, q_last_r;
  logic              close_r;
  logic signed [wpip_pkg::CoordBits-1:0] px_r, py_r;
  wpip_pkg::vertex_t v0_r, prev_r;

  logic              accept, load_acc, query_acc;
  logic [CW-1:0]     n_sat;
  logic              n_zero;

  // edge stage
  logic              edge_vld, edge_last;
  wpip_pkg::vertex_t edge_s, edge_e;
  logic              up_nxt, dn_nxt;

  // difference stage
  logic              d_vld_r, d_last_r, d_up_r, d_dn_r;
  logic signed [DW-1:0] d_dx1_r, d_dy1_r, d_dx2_r, d_dy2_r;

  // product stage
  logic              p_vld_r, p_last_r, p_up_r, p_dn_r;
  logic signed [PW-1:0] p_a_r, p_b_r;

  // accumulate
  logic signed [WW-1:0] wind_r, wind_nxt;
  logic              inc, dec;

  logic              out_valid_r, out_inside_r;
  logic signed [WW-1:0] out_winding_r;

  assign accept    = start && !busy_r;
  assign load_acc  = accept && (in_op == wpip_pkg::OpLoad);
  assign query_acc = accept && (in_op == wpip_pkg::OpQuery);

  assign n_sat  = (vertex_count_r > CW'(wpip_pkg::MaxVertices)) ?
                  CW'(wpip_pkg::MaxVertices) : vertex_count_r;
  assign n_zero = (n_sat == '0);

  assign wr_en     = load_acc;
  assign wr_data.x = in_x_coord;
  assign wr_data.y = in_y_coord;
  assign rd_en     = (query_acc && !n_zero) || issuing_r;
  assign rd_addr   = issuing_r ? rd_idx_r : '0;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[in_vertex_index] <= wr_data;
    end
    if (rd_en) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  // edges: (previous, current) as data returns, then the closing edge back to vertex 0
  assign edge_vld  = (q_vld_r && !q_first_r) || close_r;
  assign edge_last = close_r;
  assign edge_s    = prev_r;
  assign edge_e    = close_r ? v0_r : mem_q_r;

  assign up_nxt = (edge_s.y < py_r) && (edge_e.y > py_r);
  assign dn_nxt = (edge_s.y > py_r) && (edge_e.y < py_r);

  assign inc = p_up_r && (p_a_r > p_b_r);
  assign dec = p_dn_r && (p_a_r < p_b_r);

  // count holds at the ends of its range
  always_comb begin
    wind_nxt = wind_r;
    if (inc) begin
      if (wind_r != WindMax) begin
        wind_nxt = wind_r + WW'(1);
      end
    end else if (dec) begin
      if (wind_r != WindMin) begin
        wind_nxt = wind_r - WW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vertex_count_r <= '0;
      busy_r         <= 1'b0;
      issuing_r      <= 1'b0;
      q_vld_r        <= 1'b0;
      close_r        <= 1'b0;
      d_vld_r        <= 1'b0;
      p_vld_r        <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        vertex_count_r <= cfg_vertex_count;
      end

      out_valid_r <= 1'b0;

      // read issue
      if (query_acc && !n_zero) begin
        busy_r     <= 1'b1;
        issuing_r  <= (n_sat != CW'(1));
        rd_idx_r   <= AW'(1);
        last_idx_r <= AW'(n_sat - CW'(1));
        q_first_r  <= 1'b1;
        q_last_r   <= (n_sat == CW'(1));
      end else if (issuing_r) begin
        rd_idx_r  <= rd_idx_r + AW'(1);
        issuing_r <= (rd_idx_r != last_idx_r);
        q_first_r <= 1'b0;
        q_last_r  <= (rd_idx_r == last_idx_r);
      end
      q_vld_r <= rd_en;
      close_r <= q_vld_r && q_last_r;

      d_vld_r <= edge_vld;
      p_vld_r <= d_vld_r;

      if (query_acc && n_zero) begin
        out_valid_r <= 1'b1;
      end else if (p_vld_r && p_last_r) begin
        out_valid_r <= 1'b1;
        busy_r      <= 1'b0;
      end
    end
  end

  // payload path
  always_ff @(posedge clk) begin
    if (query_acc) begin
      px_r   <= in_x_coord;
      py_r   <= in_y_coord;
      wind_r <= '0;
    end else if (p_vld_r) begin
      wind_r <= p_last_r ? '0 : wind_nxt;
    end

    if (q_vld_r) begin
      prev_r <= mem_q_r;
      if (q_first_r) begin
        v0_r <= mem_q_r;
      end
    end

    d_last_r <= edge_last;
    d_up_r   <= up_nxt;
    d_dn_r   <= dn_nxt;
    d_dx1_r  <= DW'(edge_e.x) - DW'(edge_s.x);
    d_dy1_r  <= DW'(py_r) - DW'(edge_s.y);
    d_dx2_r  <= DW'(px_r) - DW'(edge_s.x);
    d_dy2_r  <= DW'(edge_e.y) - DW'(edge_s.y);

    p_last_r <= d_last_r;
    p_up_r   <= d_up_r;
    p_dn_r   <= d_dn_r;
    p_a_r    <= d_dx1_r * d_dy1_r;
    p_b_r    <= d_dx2_r * d_dy2_r;

    if (query_acc && n_zero) begin
      out_winding_r <= '0;
      out_inside_r  <= 1'b0;
    end else if (p_vld_r && p_last_r) begin
      out_winding_r <= wind_nxt;
      out_inside_r  <= (wind_nxt != '0);
    end
  end

  assign busy           = busy_r;
  assign cfg_ready      = !busy_r;
  assign out_valid      = out_valid_r;
  assign out_winding    = out_winding_r;
  assign out_inside_res = out_inside_r;

  // reads only go out while a query is running
  a_issue_busy: assert property (@(posedge clk) disable iff (!rst_n)
    issuing_r |-> busy_r)
    else $error("read issue outside a query");

  // only one closing edge in the pipeline at a time
  a_one_last: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({close_r, d_vld_r && d_last_r, p_vld_r && p_last_r}) <= 1)
    else $error("more than one query in the edge pipeline");

  // a load never produces a result beat
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    load_acc |=> !out_valid_r)
    else $error("result beat after a load");

  // the end of a query walk always gives its result
  a_fell_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy_r) |-> out_valid_r)
    else $error("query finished without a result beat");

  a_inside_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_inside_r == (out_winding_r != '0)))
    else $error("inside flag disagrees with winding count");

endmodule

`default_nettype wire
